>>> src/can_bit_timing_search_top_macros.svh
// Assertion macros for the bit-timing search block.
`ifndef CAN_BIT_TIMING_SEARCH_TOP_MACROS_SVH
`define CAN_BIT_TIMING_SEARCH_TOP_MACROS_SVH

// Check a property outside of reset.
`define CBTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CBTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/cbts_pkg.sv
`timescale 1ns / 1ps
package cbts_pkg;

  localparam int NUM_CANDIDATES = 18;
  localparam int CAND_W = $clog2(NUM_CANDIDATES);
  localparam int IN_W = 32;
  localparam int DIV_STEPS = IN_W;
  localparam int CNT_W = $clog2(DIV_STEPS);
  // 2 * 25 * (2^32 - 1) fits in 38 bits
  localparam int DVS_W = IN_W + 6;
  localparam int NTQ_W = 5;

  localparam logic [IN_W-1:0] BRP_MAX = 32'd64;
  localparam logic [5:0] SEG_MAX = 6'd8;
  localparam logic [5:0] PS2_MIN = 6'd2;
  localparam logic [7:0] CNF2_BTL = 8'h80;

  typedef struct packed {
    logic load;     // capture the input transaction
    logic start;    // set up the divisor for the current candidate
    logic step;     // one restoring division step
    logic advance;  // move to the next candidate
    logic pub_ok;   // publish the current candidate's timing
    logic pub_err;  // publish a range error
  } cbts_cmd_t;

  typedef struct packed {
    logic zero_in;    // zero frequency or zero bit rate at the input
    logic div_last;   // this division step is the final one
    logic hit;        // current candidate gives an exact, fitting timing
    logic last_cand;  // current candidate is the last one in the order
  } cbts_sts_t;

  typedef struct packed {
    logic ok;
    logic [3:0] ps1;
    logic [3:0] prop;
    logic [3:0] ps2;
  } seg_t;

  // Bit length tried at each position of the search order.
  function automatic logic [NTQ_W-1:0] tq_at(input logic [CAND_W-1:0] idx);
    logic [NTQ_W-1:0] v;
    case (idx)
      5'd0:    v = 5'd16;
      5'd1:    v = 5'd25;
      5'd2:    v = 5'd24;
      5'd3:    v = 5'd23;
      5'd4:    v = 5'd22;
      5'd5:    v = 5'd21;
      5'd6:    v = 5'd20;
      5'd7:    v = 5'd19;
      5'd8:    v = 5'd18;
      5'd9:    v = 5'd17;
      5'd10:   v = 5'd15;
      5'd11:   v = 5'd14;
      5'd12:   v = 5'd13;
      5'd13:   v = 5'd12;
      5'd14:   v = 5'd11;
      5'd15:   v = 5'd10;
      5'd16:   v = 5'd9;
      5'd17:   v = 5'd8;
      default: v = 5'd8;
    endcase
    return v;
  endfunction

  // Split a bit length into phase segments and check that they fit.
  function automatic seg_t seg_fit(input logic [NTQ_W-1:0] ntq);
    logic [5:0] n;
    logic [5:0] p2;
    logic [5:0] rest;
    logic [5:0] pr;
    logic [5:0] p1;
    seg_t s;
    n = {1'b0, ntq};
    p2 = (n + 6'd2) >> 2;
    if (p2 < PS2_MIN) begin
      p2 = PS2_MIN;
    end
    rest = n - 6'd1 - p2;
    pr = rest >> 1;
    if (pr > SEG_MAX) begin
      pr = SEG_MAX;
    end
    p1 = rest - pr;
    s.ok = (n >= p2 + 6'd1) && (p1 >= 6'd1) && (p1 <= SEG_MAX) &&
           (pr >= 6'd1) && (p2 <= SEG_MAX);
    s.ps1 = p1[3:0];
    s.prop = pr[3:0];
    s.ps2 = p2[3:0];
    return s;
  endfunction

endpackage

>>> src/can_bit_timing_search_top.sv
`timescale 1ns / 1ps
// Search steps: a zero input goes straight to publishing; otherwise each bit length tried takes a divisor
// set-up, 32 steps of the shared restoring divider and a check, for up to 18 lengths.
// Throughput: one transaction at a time; the next is taken once the result is published.
// The result register holds a finished transaction while the next one is searched.
// Reset (rst, synchronous) returns the controller to idle and drops any pending result.
module can_bit_timing_search_top
  import cbts_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] osc_frequency_hz,
  input  logic [IN_W-1:0] bit_rate,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            status,
  output logic [5:0]      cnf1_byte,
  output logic [7:0]      cnf2_byte,
  output logic [2:0]      cnf3_byte
);

  cbts_cmd_t cmd;
  cbts_sts_t sts;

  // Sequence the search
  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Divide and check each candidate
  cbts_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .osc_frequency_hz (osc_frequency_hz),
    .bit_rate         (bit_rate),
    .status           (status),
    .cnf1_byte        (cnf1_byte),
    .cnf2_byte        (cnf2_byte),
    .cnf3_byte        (cnf3_byte)
  );

endmodule

>>> src/cbts_datapath.sv
`timescale 1ns / 1ps
module cbts_datapath
  import cbts_pkg::*;
(
  input  logic            clk,
  input  cbts_cmd_t       cmd,
  output cbts_sts_t       sts,
  input  logic [IN_W-1:0] osc_frequency_hz,
  input  logic [IN_W-1:0] bit_rate,
  output logic            status,
  output logic [5:0]      cnf1_byte,
  output logic [7:0]      cnf2_byte,
  output logic [2:0]      cnf3_byte
);

  logic [IN_W-1:0]   fosc;
  logic [IN_W-1:0]   rate;
  logic [IN_W-1:0]   dvd;
  logic [IN_W-1:0]   quo;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [CAND_W-1:0] idx;
  logic [CNT_W-1:0]  cnt;

  logic [NTQ_W-1:0]  ntq;
  seg_t              seg;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    dvs_ext;
  logic              ge;

  // Decode the current candidate
  always_comb begin
    ntq = tq_at(idx);
    seg = seg_fit(ntq);
  end

  // Shift in the next dividend bit and compare against the divisor
  always_comb begin
    rem_sh = {rem, dvd[IN_W-1]};
    dvs_ext = {1'b0, dvs};
    ge = (rem_sh >= dvs_ext);
  end

  // Report status to the controller
  always_comb begin
    sts.zero_in = (osc_frequency_hz == '0) || (bit_rate == '0);
    sts.div_last = (cnt == CNT_W'(DIV_STEPS - 1));
    sts.hit = (rem == '0) && (quo != '0) && (quo <= BRP_MAX) && seg.ok;
    sts.last_cand = (idx == CAND_W'(NUM_CANDIDATES - 1));
  end

  // Hold operands, run the shared divider, advance through candidates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fosc <= osc_frequency_hz;
      rate <= bit_rate;
      idx <= '0;
    end
    if (cmd.advance) begin
      idx <= idx + CAND_W'(1);
    end
    if (cmd.start) begin
      dvs <= DVS_W'({ntq, 1'b0}) * DVS_W'(rate);
      rem <= '0;
      quo <= '0;
      dvd <= fosc;
      cnt <= '0;
    end
    if (cmd.step) begin
      rem <= ge ? DVS_W'(rem_sh - dvs_ext) : DVS_W'(rem_sh);
      quo <= {quo[IN_W-2:0], ge};
      dvd <= {dvd[IN_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.pub_ok) begin
      status <= 1'b0;
      cnf1_byte <= quo[5:0] - 6'd1;
      cnf2_byte <= CNF2_BTL | {2'b00, 3'(seg.ps1 - 4'd1), 3'(seg.prop - 4'd1)};
      cnf3_byte <= 3'(seg.ps2 - 4'd1);
    end else if (cmd.pub_err) begin
      status <= 1'b1;
      cnf1_byte <= '0;
      cnf2_byte <= '0;
      cnf3_byte <= '0;
    end
  end

endmodule

>>> src/cbts_ctrl.sv
`timescale 1ns / 1ps
module cbts_ctrl
  import cbts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cbts_sts_t sts,
  output cbts_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_START   = 5'b00010,
    S_DIV     = 5'b00100,
    S_CHECK   = 5'b01000,
    S_PUBLISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   found;
  logic   found_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sequence the search
  always_comb begin
    state_next = state;
    found_next = found;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          found_next = 1'b0;
          state_next = sts.zero_in ? S_PUBLISH : S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.hit) begin
          found_next = 1'b1;
          state_next = S_PUBLISH;
        end else if (sts.last_cand) begin
          state_next = S_PUBLISH;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_START;
        end
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.pub_ok = found;
          cmd.pub_err = !found;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state and track the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      if (cmd.pub_ok || cmd.pub_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/cbts_checker.sv
`timescale 1ns / 1ps
`include "can_bit_timing_search_top_macros.svh"
module cbts_checker
  import cbts_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic [IN_W-1:0] osc_frequency_hz,
  input logic [IN_W-1:0] bit_rate,
  input logic            out_valid,
  input logic            out_ready,
  input logic            status,
  input logic [5:0]      cnf1_byte,
  input logic [7:0]      cnf2_byte,
  input logic [2:0]      cnf3_byte
);

  // Reset drops any pending result
  `CBTS_ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !out_valid, "result valid after reset")

  // A taken transaction drops ready in the cycle after it is accepted
  `CBTS_ASSERT(a_busy_after_accept, clk, rst,
               in_valid && in_ready |=> !in_ready,
               "ready right after accept")

  // An error result carries all-zero timing bytes
  `CBTS_ASSERT(a_err_zero, clk, rst,
               out_valid && status |->
                 cnf1_byte == 6'd0 && cnf2_byte == 8'd0 && cnf3_byte == 3'd0,
               "error result with nonzero bytes")

  // A found timing has the bit-length mode bit set, bit 6 clear and phase two of at least two quanta
  `CBTS_ASSERT(a_ok_shape, clk, rst,
               out_valid && !status |-> cnf2_byte[7] && !cnf2_byte[6] && cnf3_byte != 3'd0,
               "malformed timing bytes")

  // A stalled result holds
  `CBTS_ASSERT(a_out_hold, clk, rst,
               out_valid && !out_ready |=> out_valid && $stable(cnf2_byte),
               "stalled result changed")

endmodule

bind can_bit_timing_search_top cbts_checker u_chk (.*);
